@@ src/sble_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sble_pkg
// Shared types, constants and tables of the stereo band level and phase
// estimator.
// ----------------------------------------------------------------------------
package sble_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam int CORDIC_STEPS = 30;
	localparam int TURN_W = 30;
	localparam int LOG_W = 30;
	localparam int NORM_STEPS = 6;
	localparam int SQR_STEPS = 24;

	localparam logic [29:0] DB_PER_OCTAVE_Q28 = 30'd808071242;
	localparam logic [63:0] INV_PI_Q31 = 64'd683565276;
	localparam logic signed [16:0] LEVEL_LIMIT = 17'sd51200;
	localparam logic [61:0] ENERGY_CAP = {62{1'b1}};

	typedef enum logic [0:0] {
		REG_ENERGY_FLOOR   = 1'b0,
		REG_SIDE_THRESHOLD = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		BE_IDLE,
		BE_NORM,
		BE_SQR,
		BE_MUL,
		BE_LEVEL,
		BE_CORDIC,
		BE_FINISH
	} be_state_t;

	typedef struct packed {
		logic [5:0]         band_index;
		logic [61:0]        left_energy;
		logic [61:0]        right_energy;
		logic [63:0]        side_power;
		logic signed [63:0] cross_re;
		logic signed [63:0] cross_im;
	} band_rec_t;

	typedef struct packed {
		logic      valid;
		band_rec_t rec;
	} push_t;

	typedef struct packed {
		logic      valid;
		band_rec_t rec;
	} q_head_t;

	typedef logic [CORDIC_STEPS-1:0][TURN_W-1:0] turn_tab_t;

	// long division of a table term by a small odd count, elaboration only
	function automatic longint unsigned div_small(input longint unsigned num,
		input int unsigned den);
		longint unsigned quo;
		longint unsigned rem_v;
		quo = 0;
		rem_v = 0;
		for (int b = 63; b >= 0; b--) begin
			rem_v = {rem_v[62:0], num[b]};
			if (rem_v >= 64'(den)) begin
				rem_v = rem_v - 64'(den);
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atan(2^-i) in Q32 turns, from the alternating arctan series in Q62 radians
	function automatic logic [TURN_W-1:0] turn_entry(input int i);
		longint r;
		longint t;
		longint unsigned u;
		int n;
		logic neg;
		r = 0;
		neg = 1'b0;
		if (i == 0) begin
			return TURN_W'(64'd1 << 29);
		end
		for (n = 1; n * i <= 62; n += 2) begin
			t = longint'(div_small(64'd1 << (62 - n * i), n));
			r = neg ? r - t : r + t;
			neg = !neg;
		end
		u = ((64'(r) >> 30) * INV_PI_Q31 + (64'd1 << 31)) >> 32;
		return TURN_W'(u);
	endfunction

	function automatic turn_tab_t build_turn_tab();
		turn_tab_t tab;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			tab[i] = turn_entry(i);
		end
		return tab;
	endfunction

	localparam turn_tab_t TURN_TAB = build_turn_tab();

endpackage

@@ src/sble_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sble_in_if
// Bin channel: one complex left/right bin with band and frame marks.
// ----------------------------------------------------------------------------
interface sble_in_if #(parameter int SAMPLE_WIDTH = 24) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] left_re;
	logic signed [SAMPLE_WIDTH-1:0] left_im;
	logic signed [SAMPLE_WIDTH-1:0] right_re;
	logic signed [SAMPLE_WIDTH-1:0] right_im;
	logic                           band_last;
	logic                           frame_last;

	modport source (output valid, left_re, left_im, right_re, right_im, band_last,
		frame_last, input ready);
	modport sink (input valid, left_re, left_im, right_re, right_im, band_last,
		frame_last, output ready);
endinterface

@@ src/sble_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sble_out_if
// Band result channel: energies, level difference, phase and side flag.
// ----------------------------------------------------------------------------
interface sble_out_if #(parameter int ANGLE_BITS = 16) ();
	logic                 valid;
	logic                 ready;
	logic [5:0]           band_index;
	logic [61:0]          left_energy;
	logic [61:0]          right_energy;
	logic signed [16:0]   level_difference;
	logic [ANGLE_BITS:0]  phase_difference;
	logic                 side_active;

	modport source (output valid, band_index, left_energy, right_energy,
		level_difference, phase_difference, side_active, input ready);
	modport sink (input valid, band_index, left_energy, right_energy,
		level_difference, phase_difference, side_active, output ready);
endinterface

@@ src/sble_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sble_front
// Per-bin products and band accumulators; pushes a band record at band end.
// ----------------------------------------------------------------------------
module sble_front #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int MAX_BANDS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sble_in_if.sink                      bin,
	input  logic [sble_pkg::QCNT_W-1:0]  q_count,
	output sble_pkg::push_t              push
);
	import sble_pkg::*;

	localparam int PW = 2 * SAMPLE_WIDTH;
	localparam int DW = SAMPLE_WIDTH + 1;

	function automatic logic signed [63:0] sat65(input logic signed [64:0] v);
		if (v[64] != v[63]) begin
			return v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return v[63:0];
	endfunction

	logic accept;
	logic [QCNT_W:0] inflight;

	logic valid_s1, bl_s1, fl_s1;
	logic signed [PW-1:0] ll_s1, li_s1, rr_s1, ri_s1, xrr_s1, xii_s1, xir_s1, xri_s1;
	logic [2*DW-1:0] dsq_s1;
	logic signed [DW-1:0] diff;

	logic valid_s2, bl_s2, fl_s2;
	logic [PW:0] pl_s2, pr_s2;
	logic signed [63:0] cr_s2, ci_s2;
	logic [63:0] ds_s2;

	logic [61:0] el_q, er_q;
	logic [63:0] sd_q;
	logic signed [63:0] cr_q, ci_q;
	logic [5:0] band_q;

	logic [65:0] el_sum, er_sum;
	logic [64:0] sd_sum;
	logic [61:0] el_new, er_new;
	logic [63:0] sd_new;
	logic signed [63:0] cr_new, ci_new;
	logic blk_end;

	// count band records in the queue and those still on their way into it
	assign inflight = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(valid_s1 & (bl_s1 | fl_s1))
		+ (QCNT_W+1)'(valid_s2 & (bl_s2 | fl_s2));
	assign bin.ready = inflight < (QCNT_W+1)'(QDEPTH);
	assign accept = bin.valid & bin.ready;
	assign diff = DW'(bin.left_re) - DW'(bin.right_re);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ll_s1  <= bin.left_re * bin.left_re;
			li_s1  <= bin.left_im * bin.left_im;
			rr_s1  <= bin.right_re * bin.right_re;
			ri_s1  <= bin.right_im * bin.right_im;
			xrr_s1 <= bin.left_re * bin.right_re;
			xii_s1 <= bin.left_im * bin.right_im;
			xir_s1 <= bin.left_im * bin.right_re;
			xri_s1 <= bin.left_re * bin.right_im;
			dsq_s1 <= diff * diff;
			bl_s1  <= bin.band_last;
			fl_s1  <= bin.frame_last;
		end
		pl_s2 <= (PW+1)'($unsigned(ll_s1)) + (PW+1)'($unsigned(li_s1));
		pr_s2 <= (PW+1)'($unsigned(rr_s1)) + (PW+1)'($unsigned(ri_s1));
		cr_s2 <= sat65(65'(xrr_s1) + 65'(xii_s1));
		ci_s2 <= sat65(65'(xir_s1) - 65'(xri_s1));
		ds_s2 <= 64'(dsq_s1);
		bl_s2 <= bl_s1;
		fl_s2 <= fl_s1;
	end

	always_comb begin
		el_sum = 66'(el_q) + 66'(pl_s2);
		er_sum = 66'(er_q) + 66'(pr_s2);
		sd_sum = 65'(sd_q) + 65'(ds_s2);
		el_new = (el_sum >= 66'(ENERGY_CAP)) ? ENERGY_CAP : el_sum[61:0];
		er_new = (er_sum >= 66'(ENERGY_CAP)) ? ENERGY_CAP : er_sum[61:0];
		sd_new = sd_sum[64] ? {64{1'b1}} : sd_sum[63:0];
		cr_new = sat65(65'(cr_q) + 65'(cr_s2));
		ci_new = sat65(65'(ci_q) + 65'(ci_s2));
		blk_end = bl_s2 | fl_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			el_q   <= '0;
			er_q   <= '0;
			sd_q   <= '0;
			cr_q   <= '0;
			ci_q   <= '0;
			band_q <= '0;
		end else if (valid_s2) begin
			if (blk_end) begin
				el_q <= '0;
				er_q <= '0;
				sd_q <= '0;
				cr_q <= '0;
				ci_q <= '0;
				if (fl_s2 || band_q == 6'(MAX_BANDS - 1)) begin
					band_q <= '0;
				end else begin
					band_q <= band_q + 6'd1;
				end
			end else begin
				el_q <= el_new;
				er_q <= er_new;
				sd_q <= sd_new;
				cr_q <= cr_new;
				ci_q <= ci_new;
			end
		end
	end

	always_comb begin
		push.valid            = valid_s2 & blk_end;
		push.rec.band_index   = band_q;
		push.rec.left_energy  = el_new;
		push.rec.right_energy = er_new;
		push.rec.side_power   = sd_new;
		push.rec.cross_re     = cr_new;
		push.rec.cross_im     = ci_new;
	end

endmodule

@@ src/sble_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sble_queue
// Short queue of finished band records between the front and back ends.
// ----------------------------------------------------------------------------
module sble_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sble_pkg::push_t              push,
	input  logic                         pop,
	output sble_pkg::q_head_t            head,
	output logic [sble_pkg::QCNT_W-1:0]  count
);
	import sble_pkg::*;

	band_rec_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push.valid) - QCNT_W'(pop);
		end
	end

	assign head.valid = count_q != '0;
	assign head.rec   = mem_q[rd_ptr_q];
	assign count      = count_q;

endmodule

@@ src/sble_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sble_back
// Per-band level (log2 by repeated squaring) and phase (CORDIC vectoring).
// ----------------------------------------------------------------------------
module sble_back #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sble_pkg::q_head_t    head,
	output logic                 pop,
	input  logic [15:0]          energy_floor,
	input  logic [61:0]          side_threshold,
	sble_out_if.source           band
);
	import sble_pkg::*;

	function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v,
		input logic [4:0] s);
		logic signed [63:0] n;
		n = -v;
		return v[63] ? -(n >>> s) : (v >>> s);
	endfunction

	be_state_t state_q, state_d;
	logic [4:0] step_q;
	logic selb_q;

	band_rec_t rec_q;
	logic [63:0] va_q;
	logic [5:0] e_q;
	logic [31:0] m_q;
	logic [LOG_W-1:0] lg_q, la_q;
	logic signed [61:0] p_q;
	logic signed [16:0] lv_q;
	logic side_q;
	logic signed [63:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic zero_q, yz_q, xz_q;

	logic out_valid_q;
	logic [5:0] o_band_q;
	logic [61:0] o_le_q, o_re_q;
	logic signed [16:0] o_lv_q;
	logic [ANGLE_BITS:0] o_ph_q;
	logic o_side_q;

	logic [62:0] a_head, b_rec;
	logic [5:0] shamt;
	logic [63:0] top, nv;
	logic [5:0] ne;
	logic [63:0] sq;
	logic [32:0] t;
	logic [LOG_W-1:0] lg_inc, lg_nx;
	logic [31:0] m_nx;
	logic signed [30:0] dlog;
	logic [61:0] magp;
	logic [17:0] qmag;
	logic signed [16:0] lv_val;
	logic az, bz;
	logic [63:0] ax, ay, orv, axs, ays;
	logic [2:0] sh;
	logic signed [63:0] dx, dy;
	logic signed [33:0] tab;
	logic signed [33:0] zc;
	logic [32:0] ang;
	logic [32:0] rnd;
	logic [ANGLE_BITS-1:0] pcode;
	logic [ANGLE_BITS:0] phase;
	logic out_free;

	assign out_free = !out_valid_q || band.ready;

	// next state
	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		unique case (state_q)
			BE_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					state_d = BE_NORM;
				end
			end
			BE_NORM: begin
				if (step_q == 5'(NORM_STEPS - 1)) state_d = BE_SQR;
			end
			BE_SQR: begin
				if (step_q == 5'(SQR_STEPS - 1)) state_d = selb_q ? BE_MUL : BE_NORM;
			end
			BE_MUL: state_d = BE_LEVEL;
			BE_LEVEL: state_d = BE_CORDIC;
			BE_CORDIC: begin
				if (step_q == 5'(CORDIC_STEPS - 1)) state_d = BE_FINISH;
			end
			BE_FINISH: begin
				if (out_free) state_d = BE_IDLE;
			end
			default: state_d = BE_IDLE;
		endcase
	end

	// datapath
	always_comb begin
		a_head = 63'(head.rec.left_energy) + 63'(energy_floor);
		b_rec  = 63'(rec_q.right_energy) + 63'(energy_floor);

		// one binary step of the leading-one search
		shamt = 6'd32 >> step_q[2:0];
		top   = va_q >> (7'd64 - 7'(shamt));
		nv    = (top == '0) ? (va_q << shamt) : va_q;
		ne    = (top == '0) ? (e_q - shamt) : e_q;

		sq     = 64'(m_q) * 64'(m_q);
		t      = sq[63:31];
		lg_inc = LOG_W'(1) << (5'd23 - step_q);
		lg_nx  = t[32] ? (lg_q | lg_inc) : lg_q;
		m_nx   = t[32] ? t[32:1] : t[31:0];

		dlog = $signed({1'b0, la_q}) - $signed({1'b0, lg_q});

		magp = p_q[61] ? 62'(-p_q) : 62'(p_q);
		qmag = 18'((magp + (62'd1 << 43)) >> 44);
		if (qmag > 18'(LEVEL_LIMIT)) qmag = 18'(LEVEL_LIMIT);
		az = (rec_q.left_energy == '0) && (energy_floor == '0);
		bz = (rec_q.right_energy == '0) && (energy_floor == '0);
		priority if (az && bz) lv_val = '0;
		else if (az) lv_val = -LEVEL_LIMIT;
		else if (bz) lv_val = LEVEL_LIMIT;
		else lv_val = p_q[61] ? -$signed(17'(qmag)) : $signed(17'(qmag));

		ax  = rec_q.cross_re[63] ? -rec_q.cross_re : rec_q.cross_re;
		ay  = rec_q.cross_im[63] ? -rec_q.cross_im : rec_q.cross_im;
		orv = ax | ay;
		priority if (orv[63]) sh = 3'd4;
		else if (orv[62]) sh = 3'd3;
		else if (orv[61]) sh = 3'd2;
		else if (orv[60]) sh = 3'd1;
		else sh = 3'd0;
		axs = ax >> sh;
		ays = ay >> sh;

		dx  = shr_tz(y_q, step_q);
		dy  = shr_tz(x_q, step_q);
		tab = $signed(34'(TURN_TAB[step_q]));

		priority if (yz_q) zc = '0;
		else if (xz_q) zc = 34'sd1 << 30;
		else if (z_q < 0) zc = '0;
		else if (z_q > (34'sd1 << 30)) zc = 34'sd1 << 30;
		else zc = z_q;

		// map the first-quadrant angle to its quadrant, Q32 turns
		priority if (!rec_q.cross_re[63] && !rec_q.cross_im[63]) ang = 33'(zc);
		else if (rec_q.cross_re[63] && !rec_q.cross_im[63]) ang = (33'd1 << 31) - 33'(zc);
		else if (rec_q.cross_re[63]) ang = (33'd1 << 31) + 33'(zc);
		else ang = (33'd1 << 32) - 33'(zc);
		rnd   = 33'(ang[31:0]) + (33'd1 << (31 - ANGLE_BITS));
		pcode = rnd[31 -: ANGLE_BITS];
		if (zero_q || pcode == '0) phase = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
		else phase = {1'b0, pcode};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BE_IDLE;
			step_q      <= '0;
			selb_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				BE_IDLE: begin
					step_q <= '0;
					selb_q <= 1'b0;
				end
				BE_NORM: step_q <= (step_q == 5'(NORM_STEPS - 1)) ? '0 : step_q + 5'd1;
				BE_SQR: begin
					step_q <= (step_q == 5'(SQR_STEPS - 1)) ? '0 : step_q + 5'd1;
					if (step_q == 5'(SQR_STEPS - 1)) selb_q <= 1'b1;
				end
				BE_MUL, BE_LEVEL: step_q <= '0;
				BE_CORDIC: step_q <= step_q + 5'd1;
				BE_FINISH: step_q <= '0;
				default: step_q <= '0;
			endcase
			if (state_q == BE_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (band.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BE_IDLE: begin
				rec_q <= head.rec;
				va_q  <= {1'b0, a_head};
				e_q   <= 6'd63;
			end
			BE_NORM: begin
				va_q <= nv;
				e_q  <= ne;
				if (step_q == 5'(NORM_STEPS - 1)) begin
					m_q  <= nv[63:32];
					lg_q <= {ne, 24'd0};
				end
			end
			BE_SQR: begin
				m_q  <= m_nx;
				lg_q <= lg_nx;
				if (step_q == 5'(SQR_STEPS - 1) && !selb_q) begin
					la_q <= lg_nx;
					va_q <= {1'b0, b_rec};
					e_q  <= 6'd63;
				end
			end
			BE_MUL: begin
				p_q <= dlog * $signed({1'b0, DB_PER_OCTAVE_Q28});
			end
			BE_LEVEL: begin
				lv_q   <= lv_val;
				side_q <= rec_q.side_power > {side_threshold, 2'b00};
				x_q    <= $signed(axs);
				y_q    <= $signed(ays);
				z_q    <= '0;
				zero_q <= (ax == '0) && (ay == '0);
				yz_q   <= ays == '0;
				xz_q   <= axs == '0;
			end
			BE_CORDIC: begin
				if (y_q > 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + tab;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - tab;
				end
			end
			BE_FINISH: begin
				if (out_free) begin
					o_band_q <= rec_q.band_index;
					o_le_q   <= rec_q.left_energy;
					o_re_q   <= rec_q.right_energy;
					o_lv_q   <= lv_q;
					o_ph_q   <= phase;
					o_side_q <= side_q;
				end
			end
			default: ;
		endcase
	end

	assign band.valid            = out_valid_q;
	assign band.band_index       = o_band_q;
	assign band.left_energy      = o_le_q;
	assign band.right_energy     = o_re_q;
	assign band.level_difference = o_lv_q;
	assign band.phase_difference = o_ph_q;
	assign band.side_active      = o_side_q;

endmodule

@@ src/stereo_band_level_phase_estimator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_band_level_phase_estimator_top
// Band energies, inter-channel level difference and phase per spectral band.
// ----------------------------------------------------------------------------
// One bin is taken per clock on the bin channel as long as the band queue has
// room; the front end has two register stages, and a band record is pushed
// into the queue from the second one. Each band end (band_last or frame_last)
// hands a band record to a four-entry queue. The back end works on one band at
// a time: a load state, two log2 evaluations of 6 leading-one steps plus 24
// squaring steps each, a multiply state and a level state, 30 CORDIC steps and
// an output state that waits while the band channel is stalled. Bands that
// arrive faster than the back end works fill the queue; then bin.ready drops.
// Configuration writes are taken at once and must only happen while idle.
module stereo_band_level_phase_estimator_top #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int ANGLE_BITS = 16,
	parameter int MAX_BANDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	sble_in_if.sink     bin,
	sble_out_if.source  band,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [61:0] cfg_data
);
	import sble_pkg::*;

	logic [15:0] floor_q;
	logic [61:0] thr_q;
	push_t push;
	q_head_t head;
	logic pop;
	logic [QCNT_W-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= 16'd1;
			thr_q   <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_ENERGY_FLOOR:   floor_q <= cfg_data[15:0];
				REG_SIDE_THRESHOLD: thr_q   <= cfg_data;
			endcase
		end
	end

	sble_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.MAX_BANDS    (MAX_BANDS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.bin     (bin),
		.q_count (q_count),
		.push    (push)
	);

	sble_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.count  (q_count)
	);

	sble_back #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.energy_floor   (floor_q),
		.side_threshold (thr_q),
		.band           (band)
	);

`ifndef ASSERT_OFF
	a_queue_bound : assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QDEPTH))
		else $error("band queue count beyond depth");

	a_no_overflow : assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && !pop |-> q_count < QCNT_W'(QDEPTH))
		else $error("band record pushed into a full queue");

	a_phase_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		band.valid |-> band.phase_difference != '0)
		else $error("phase code zero");

	a_level_range : assert property (@(posedge clk) disable iff (!arst_n)
		band.valid |-> (band.level_difference <= LEVEL_LIMIT)
			&& (band.level_difference >= -LEVEL_LIMIT))
		else $error("level difference out of range");
`endif

endmodule
